FILE: design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types, constants and width helpers for the 4x4 matrix-vector
// transform core.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int FIELD_WIDTH    = 32;
   localparam int CMD_WIDTH      = 2;
   localparam int GROUP_WIDTH    = 2;
   localparam int DIM            = 4;
   localparam int NUM_STAGES     = 6;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_VECTOR = 2'd1,
      CMD_POINT  = 2'd2
   } cmd_type;

   // width that holds any exact product, including the point-mode shift
   function automatic int prod_width(input int dw, input int fb);
      return (2 * dw > dw + fb + 1) ? 2 * dw : dw + fb + 1;
   endfunction

endpackage

FILE: design/matrix4_vector_transform_core.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_core
// 4x4 fixed-point matrix times vector transform with a loadable matrix.
//
// Input channel (req_*): cmd 0 loads group req_group_index of the matrix from
// the four components and yields no result; cmd 1 transforms a full vector;
// cmd 2 transforms a point (implied w of one, out_w forced to zero); cmd 3 is
// dropped. A load takes effect for the very next transfer.
// Result channel (rsp_*): one transfer per transform, in order, with a flag
// set when any produced component was clamped.
// The path from input transfer to rsp_valid has 3 multiplier stages and
// 3 reduce/round/saturate stages. Throughput: one item per cycle except while req_stall is high.
// Reset clears the matrix to zero and empties the pipeline.
// When rsp_stall holds a result, stages behind it keep filling bubbles; input
// stalls only once every stage holds an item. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module matrix4_vector_transform_core #(
   parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [mvt_pkg::CMD_WIDTH-1:0]            req_cmd,
   input  logic [mvt_pkg::GROUP_WIDTH-1:0]          req_group_index,
   input  logic signed [mvt_pkg::FIELD_WIDTH-1:0]   req_comp_x,
   input  logic signed [mvt_pkg::FIELD_WIDTH-1:0]   req_comp_y,
   input  logic signed [mvt_pkg::FIELD_WIDTH-1:0]   req_comp_z,
   input  logic signed [mvt_pkg::FIELD_WIDTH-1:0]   req_comp_w,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [mvt_pkg::FIELD_WIDTH-1:0]   rsp_out_x,
   output logic signed [mvt_pkg::FIELD_WIDTH-1:0]   rsp_out_y,
   output logic signed [mvt_pkg::FIELD_WIDTH-1:0]   rsp_out_z,
   output logic signed [mvt_pkg::FIELD_WIDTH-1:0]   rsp_out_w,
   output logic                                     rsp_saturated
);
   import mvt_pkg::*;

   localparam int PW = prod_width(DATA_WIDTH, FRAC_BITS);

   logic signed [DATA_WIDTH-1:0] matrix_ff [DIM*DIM];
   logic signed [DATA_WIDTH-1:0] vec_in [DIM];
   logic signed [PW-1:0]         prod [DIM][DIM];
   logic signed [DATA_WIDTH-1:0] col_res [DIM];
   logic [DIM-1:0]               col_sat;

   logic [NUM_STAGES:1]          valid_ff, valid_in;
   logic [NUM_STAGES:1]          point_ff, point_in;
   logic [NUM_STAGES:1]          adv;
   logic                         accept;
   logic                         is_xform;
   logic                         is_load;
   logic                         is_point;

   assign vec_in[0] = DATA_WIDTH'(req_comp_x);
   assign vec_in[1] = DATA_WIDTH'(req_comp_y);
   assign vec_in[2] = DATA_WIDTH'(req_comp_z);
   assign vec_in[3] = DATA_WIDTH'(req_comp_w);

   always_comb begin
      is_load  = 1'b0;
      is_xform = 1'b0;
      is_point = 1'b0;
      case (req_cmd)
         CMD_LOAD: begin
            is_load = 1'b1;
         end
         CMD_VECTOR: begin
            is_xform = 1'b1;
         end
         CMD_POINT: begin
            is_xform = 1'b1;
            is_point = 1'b1;
         end
         default: begin
            is_load = 1'b0;
         end
      endcase
   end

   // stage k may load when empty or when its item moves on
   always_comb begin
      adv[NUM_STAGES] = !valid_ff[NUM_STAGES] || !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[1];
   assign accept    = req_valid && adv[1];

   always_comb begin
      valid_in[1] = accept && is_xform;
      point_in[1] = is_point;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
         point_in[k] = point_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
         if (adv[k]) begin
            point_ff[k] <= point_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < DIM * DIM; e++) begin
            matrix_ff[e] <= '0;
         end
      end else if (accept && is_load) begin
         for (int j = 0; j < DIM; j++) begin
            matrix_ff[{req_group_index, 2'(j)}] <= vec_in[j];
         end
      end
   end

   for (genvar i = 0; i < DIM; i++) begin : g_row
      for (genvar j = 0; j < DIM; j++) begin : g_col
         mvt_mult #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS)
         ) u_mult (
            .clock  (clock),
            .en     (adv[3:1]),
            .a      (matrix_ff[i*DIM+j]),
            .b      (vec_in[i]),
            .point  ((i == DIM - 1) && is_point),
            .product(prod[j][i])
         );
      end
   end

   for (genvar j = 0; j < DIM; j++) begin : g_red
      mvt_column #(
         .DATA_WIDTH(DATA_WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_column (
         .clock (clock),
         .en    (adv[6:4]),
         .prod  (prod[j]),
         .result(col_res[j]),
         .sat   (col_sat[j])
      );
   end

   assign rsp_valid     = valid_ff[NUM_STAGES];
   assign rsp_out_x     = FIELD_WIDTH'($unsigned(col_res[0]));
   assign rsp_out_y     = FIELD_WIDTH'($unsigned(col_res[1]));
   assign rsp_out_z     = FIELD_WIDTH'($unsigned(col_res[2]));
   assign rsp_out_w     = point_ff[NUM_STAGES] ? '0 : FIELD_WIDTH'($unsigned(col_res[3]));
   assign rsp_saturated = (|col_sat[2:0]) || (!point_ff[NUM_STAGES] && col_sat[3]);

   // loads and dropped commands take no pipeline slot
   a_load_no_slot: assert property (@(posedge clock) disable iff (reset)
      accept && !is_xform |=> !valid_ff[1])
      else $error("non-transform transfer entered pipeline");

   a_xform_slot: assert property (@(posedge clock) disable iff (reset)
      accept && is_xform |=> valid_ff[1])
      else $error("transform transfer lost at stage 1");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("input stalled with a bubble in the pipeline");

   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !adv[1] |=> valid_ff[1] && $stable(point_ff[1]))
      else $error("blocked stage 1 item changed");

   a_point_w: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && point_ff[NUM_STAGES] |-> rsp_out_w == '0)
      else $error("point result with nonzero w");

endmodule

FILE: design/mvt_mult.sv
// ----------------------------------------------------------------------------
// mvt_mult
// Three-stage signed multiplier: half-width partial products, cross-term
// merge, final product. In point mode the product is the entry shifted up
// by the fraction width.
// ----------------------------------------------------------------------------
module mvt_mult #(
   parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic [2:0]                            en,
   input  logic signed [DATA_WIDTH-1:0]          a,
   input  logic signed [DATA_WIDTH-1:0]          b,
   input  logic                                  point,
   output logic signed [mvt_pkg::prod_width(DATA_WIDTH, FRAC_BITS)-1:0] product
);
   import mvt_pkg::*;

   localparam int PW = prod_width(DATA_WIDTH, FRAC_BITS);
   localparam int H  = (DATA_WIDTH + 1) / 2;
   localparam int HI = DATA_WIDTH - H;
   localparam int CW = DATA_WIDTH + 2;

   logic signed [HI-1:0]       ah, bh;
   logic        [H-1:0]        al, bl;

   logic signed [2*HI-1:0]     hh_ff, hh_in;
   logic signed [HI+H:0]       hl_ff, hl_in;
   logic signed [HI+H:0]       lh_ff, lh_in;
   logic        [2*H-1:0]      ll_ff, ll_in;
   logic signed [DATA_WIDTH-1:0] a1_ff, a2_ff;
   logic                       pt1_ff, pt2_ff;

   logic signed [CW-1:0]       cross_ff, cross_in;
   logic [2*DATA_WIDTH-1:0]    full_ff;
   logic signed [PW-1:0]       prod_ff, prod_in;

   assign ah = a[DATA_WIDTH-1:H];
   assign al = a[H-1:0];
   assign bh = b[DATA_WIDTH-1:H];
   assign bl = b[H-1:0];

   always_comb begin
      hh_in    = ah * bh;
      hl_in    = ah * $signed({1'b0, bl});
      lh_in    = $signed({1'b0, al}) * bh;
      ll_in    = al * bl;
      cross_in = CW'(hl_ff) + CW'(lh_ff);
      if (pt2_ff) begin
         prod_in = PW'(a2_ff) <<< FRAC_BITS;
      end else begin
         prod_in = PW'($signed(full_ff)) + (PW'(cross_ff) <<< H);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         lh_ff  <= lh_in;
         ll_ff  <= ll_in;
         a1_ff  <= a;
         pt1_ff <= point;
      end
      if (en[1]) begin
         cross_ff <= cross_in;
         full_ff  <= {hh_ff, ll_ff};
         a2_ff    <= a1_ff;
         pt2_ff   <= pt1_ff;
      end
      if (en[2]) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

FILE: design/mvt_column.sv
// ----------------------------------------------------------------------------
// mvt_column
// Three-stage column reducer: pair sums, total plus rounding half, then
// shift, saturate and register the result.
// ----------------------------------------------------------------------------
module mvt_column #(
   parameter int DATA_WIDTH = mvt_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic [2:0]                   en,
   input  logic signed [mvt_pkg::prod_width(DATA_WIDTH, FRAC_BITS)-1:0] prod [mvt_pkg::DIM],
   output logic signed [DATA_WIDTH-1:0] result,
   output logic                         sat
);
   import mvt_pkg::*;

   localparam int PW = prod_width(DATA_WIDTH, FRAC_BITS);
   localparam int SW = PW + 2;
   localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
   localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic signed [PW:0]           s01_ff, s23_ff;
   logic signed [SW-1:0]         tot_ff, tot_in;
   logic [SW-FRAC_BITS-DATA_WIDTH:0] top_bits;
   logic                         ovf;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;
   logic                         sat_ff;

   always_comb begin
      tot_in   = SW'(s01_ff) + SW'(s23_ff) + HALF;
      top_bits = tot_ff[SW-1:FRAC_BITS+DATA_WIDTH-1];
      ovf      = !((&top_bits) || (~|top_bits));
      if (ovf) begin
         res_in = tot_ff[SW-1] ? MINV : MAXV;
      end else begin
         res_in = tot_ff[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s01_ff <= (PW+1)'(prod[0]) + (PW+1)'(prod[1]);
         s23_ff <= (PW+1)'(prod[2]) + (PW+1)'(prod[3]);
      end
      if (en[1]) begin
         tot_ff <= tot_in;
      end
      if (en[2]) begin
         res_ff <= res_in;
         sat_ff <= ovf;
      end
   end

   assign result = res_ff;
   assign sat    = sat_ff;

endmodule
